// ----- hdl/tde_pkg.sv -----
// ----------------------------------------------------------------------------
// tde_pkg
// Shared field widths and command / result codes of the trie dictionary engine.
// ----------------------------------------------------------------------------
package tde_pkg;

  // Request and result field widths
  localparam int CMD_W    = 2;
  localparam int LETTER_W = 5;
  localparam int KEY_W    = 16;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_INS_LETTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INS_FINISH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LKP_LETTER = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LKP_FINISH = 2'd3;

  // Result kinds
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

endpackage

// ----- hdl/tde_if.sv -----
// ----------------------------------------------------------------------------
// tde_if
// Valid/ready channels of the trie dictionary engine: request in, result out.
// ----------------------------------------------------------------------------
interface tde_in_if;
  logic                         valid;
  logic                         ready;
  logic [tde_pkg::CMD_W-1:0]    command;
  logic [tde_pkg::LETTER_W-1:0] letter;
  logic [tde_pkg::KEY_W-1:0]    key_value;

  modport source (output valid, command, letter, key_value, input ready);
  modport sink   (input valid, command, letter, key_value, output ready);
endinterface

interface tde_out_if;
  logic                      valid;
  logic                      ready;
  logic                      op_kind;
  logic                      found;
  logic [tde_pkg::KEY_W-1:0] found_value;
  logic                      pool_full;

  modport source (output valid, op_kind, found, found_value, pool_full, input ready);
  modport sink   (input valid, op_kind, found, found_value, pool_full, output ready);
endinterface

// ----- hdl/tde_ram.sv -----
// ----------------------------------------------------------------------------
// tde_ram
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data.
// ----------------------------------------------------------------------------
module tde_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/trie_dictionary_engine_top.sv -----
// ----------------------------------------------------------------------------
// trie_dictionary_engine_top
// Array-based trie: insert and look up keys sent one letter per request.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all NODE_COUNT node rows
// (4096 by default), one node row per cycle, and takes no request until it
// is done. A letter request reads the child row of the current node from the
// child RAM, then follows the child or allocates a fresh node and writes the
// row back; no new request is taken until this read-then-update is done. A
// letter that is out of range or follows a failed walk skips the RAM read. An
// insert finish writes the value RAM; a lookup finish reads it and loads the
// result register from the word read. A finish is taken only when the result
// register is empty or being drained in the same cycle.
module trie_dictionary_engine_top #(
  parameter int NODE_COUNT    = 4096,
  parameter int ALPHABET_SIZE = 26,
  parameter int VALUE_BITS    = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tde_in_if.sink    in_ch,
  tde_out_if.source out_ch
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int NF_W   = $clog2(NODE_COUNT + 1);
  localparam int LET_W  = $clog2(ALPHABET_SIZE);
  localparam int ROW_W  = ALPHABET_SIZE * NODE_W;
  localparam int VAL_W  = VALUE_BITS + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_VREAD = 2'd2;

  // Control state
  logic [1:0]      state_r, state_nxt;
  logic            clearing_r, clearing_nxt;
  logic [NODE_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [NODE_W-1:0] cursor_r, cursor_nxt;
  logic [NF_W-1:0] next_free_r, next_free_nxt;
  logic            walk_failed_r, walk_failed_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Payload registers
  logic [LET_W-1:0]          ltr_idx_r, ltr_idx_nxt;
  logic                      is_ins_r, is_ins_nxt;
  logic                      op_kind_r, op_kind_nxt;
  logic                      found_r, found_nxt;
  logic [tde_pkg::KEY_W-1:0] found_value_r, found_value_nxt;
  logic                      pool_full_r, pool_full_nxt;

  // Memory ports
  logic              cm_wr_en, cm_rd_en;
  logic [NODE_W-1:0] cm_wr_addr;
  logic [ROW_W-1:0]  cm_wr_data, cm_rd_data, row_upd;
  logic              vm_wr_en, vm_rd_en;
  logic [NODE_W-1:0] vm_wr_addr;
  logic [VAL_W-1:0]  vm_wr_data, vm_rd_data;

  // Request decode
  logic              in_ready, req_acc, is_letter, ltr_ok, walk_go;
  logic              out_pop;
  logic [NODE_W-1:0] child;
  logic              has_child, can_alloc, alloc;

  assign in_ready  = (state_r == ST_IDLE) && !clearing_r && (!out_valid_r || out_ch.ready);
  assign req_acc   = in_ch.valid && in_ready;
  assign is_letter = (in_ch.command == tde_pkg::CMD_INS_LETTER) ||
                     (in_ch.command == tde_pkg::CMD_LKP_LETTER);
  assign ltr_ok    = 32'(in_ch.letter) < 32'(ALPHABET_SIZE);
  assign walk_go   = req_acc && is_letter && ltr_ok && !walk_failed_r;
  assign out_pop   = out_valid_r && out_ch.ready;

  // Child slot of the row just read, and the row with a new child filled in
  assign child     = cm_rd_data[ltr_idx_r * NODE_W +: NODE_W];
  assign has_child = child != '0;
  assign can_alloc = is_ins_r && (next_free_r < NF_W'(NODE_COUNT));
  assign alloc     = (state_r == ST_WALK) && !has_child && can_alloc;

  always_comb begin
    row_upd = cm_rd_data;
    row_upd[ltr_idx_r * NODE_W +: NODE_W] = NODE_W'(next_free_r);
  end

  // Child RAM: clear pass, or write back the row on allocation
  assign cm_rd_en   = walk_go;
  assign cm_wr_en   = clearing_r || alloc;
  assign cm_wr_addr = clearing_r ? clr_cnt_r : cursor_r;
  assign cm_wr_data = clearing_r ? '0 : row_upd;

  // Value RAM: clear pass, or store on a successful insert finish
  assign vm_rd_en   = req_acc && (in_ch.command == tde_pkg::CMD_LKP_FINISH);
  assign vm_wr_en   = clearing_r ||
                      (req_acc && (in_ch.command == tde_pkg::CMD_INS_FINISH) && !walk_failed_r);
  assign vm_wr_addr = clearing_r ? clr_cnt_r : cursor_r;
  assign vm_wr_data = clearing_r ? '0 : {1'b1, VALUE_BITS'(in_ch.key_value)};

  tde_ram #(.DEPTH(NODE_COUNT), .WIDTH(ROW_W)) u_child_ram (
    .clk     (clk),
    .wr_en   (cm_wr_en),
    .wr_addr (cm_wr_addr),
    .wr_data (cm_wr_data),
    .rd_en   (cm_rd_en),
    .rd_addr (cursor_r),
    .rd_data (cm_rd_data)
  );

  tde_ram #(.DEPTH(NODE_COUNT), .WIDTH(VAL_W)) u_value_ram (
    .clk     (clk),
    .wr_en   (vm_wr_en),
    .wr_addr (vm_wr_addr),
    .wr_data (vm_wr_data),
    .rd_en   (vm_rd_en),
    .rd_addr (cursor_r),
    .rd_data (vm_rd_data)
  );

  // Next-state logic
  always_comb begin
    state_nxt       = state_r;
    clearing_nxt    = clearing_r;
    clr_cnt_nxt     = clr_cnt_r;
    cursor_nxt      = cursor_r;
    next_free_nxt   = next_free_r;
    walk_failed_nxt = walk_failed_r;
    out_valid_nxt   = out_valid_r && !out_pop;
    ltr_idx_nxt     = ltr_idx_r;
    is_ins_nxt      = is_ins_r;
    op_kind_nxt     = op_kind_r;
    found_nxt       = found_r;
    found_value_nxt = found_value_r;
    pool_full_nxt   = pool_full_r;

    // Clearing pass after reset
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == NODE_W'(NODE_COUNT - 1)) begin
        clearing_nxt = 1'b0;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (req_acc) begin
          case (in_ch.command)
            tde_pkg::CMD_INS_LETTER, tde_pkg::CMD_LKP_LETTER: begin
              if (walk_go) begin
                ltr_idx_nxt = LET_W'(in_ch.letter);
                is_ins_nxt  = in_ch.command == tde_pkg::CMD_INS_LETTER;
                state_nxt   = ST_WALK;
              end
            end
            tde_pkg::CMD_INS_FINISH: begin
              out_valid_nxt   = 1'b1;
              op_kind_nxt     = tde_pkg::OP_INSERT;
              found_nxt       = 1'b0;
              found_value_nxt = '0;
              pool_full_nxt   = walk_failed_r;
              cursor_nxt      = '0;
              walk_failed_nxt = 1'b0;
            end
            tde_pkg::CMD_LKP_FINISH: begin
              state_nxt = ST_VREAD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      // Follow the child, allocate one, or fail the walk
      ST_WALK: begin
        state_nxt = ST_IDLE;
        if (has_child) begin
          cursor_nxt = child;
        end else if (can_alloc) begin
          cursor_nxt    = NODE_W'(next_free_r);
          next_free_nxt = next_free_r + 1'b1;
        end else begin
          walk_failed_nxt = 1'b1;
        end
      end
      // Lookup finish: value word is now available
      ST_VREAD: begin
        state_nxt       = ST_IDLE;
        out_valid_nxt   = 1'b1;
        op_kind_nxt     = tde_pkg::OP_LOOKUP;
        found_nxt       = !walk_failed_r && vm_rd_data[VALUE_BITS];
        found_value_nxt = (!walk_failed_r && vm_rd_data[VALUE_BITS]) ?
                          tde_pkg::KEY_W'(vm_rd_data[VALUE_BITS-1:0]) : '0;
        pool_full_nxt   = 1'b0;
        cursor_nxt      = '0;
        walk_failed_nxt = 1'b0;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      clearing_r    <= 1'b1;
      clr_cnt_r     <= '0;
      cursor_r      <= '0;
      next_free_r   <= NF_W'(1);
      walk_failed_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clearing_r    <= clearing_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      cursor_r      <= cursor_nxt;
      next_free_r   <= next_free_nxt;
      walk_failed_r <= walk_failed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ltr_idx_r     <= ltr_idx_nxt;
    is_ins_r      <= is_ins_nxt;
    op_kind_r     <= op_kind_nxt;
    found_r       <= found_nxt;
    found_value_r <= found_value_nxt;
    pool_full_r   <= pool_full_nxt;
  end

  // Port drive
  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.op_kind     = op_kind_r;
  assign out_ch.found       = found_r;
  assign out_ch.found_value = found_value_r;
  assign out_ch.pool_full   = pool_full_r;

  // Checks
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= NF_W'(NODE_COUNT))
    else $error("node pool pointer past the pool size");

  a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    NF_W'(cursor_r) < next_free_r)
    else $error("cursor points at an unallocated node");

  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    alloc |=> (next_free_r == $past(next_free_r) + 1'b1) &&
              (NF_W'(cursor_r) == $past(next_free_r)))
    else $error("allocation did not advance the pool and cursor together");

  a_no_req_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !vm_rd_en && !cm_rd_en && (state_r == ST_IDLE))
    else $error("request handled during the clearing pass");

endmodule
